[rtl/tekd_pkg.sv]
// tekd_pkg: shared byte codes, key numbers and types for the escape key decoder
`timescale 1ns / 1ps

package tekd_pkg;

  // terminal byte codes
  localparam logic [7:0] BYTE_NUL   = 8'd0;
  localparam logic [7:0] BYTE_ETX   = 8'd3;
  localparam logic [7:0] BYTE_ESC   = 8'd27;
  localparam logic [7:0] BYTE_CSI   = 8'd91;
  localparam logic [7:0] BYTE_SS3   = 8'd79;
  localparam logic [7:0] BYTE_TILDE = 8'd126;
  localparam logic [7:0] BYTE_DEL   = 8'd127;

  // named key numbers
  localparam logic [7:0] KEY_UP    = 8'd0;
  localparam logic [7:0] KEY_DOWN  = 8'd1;
  localparam logic [7:0] KEY_RIGHT = 8'd2;
  localparam logic [7:0] KEY_LEFT  = 8'd3;
  localparam logic [7:0] KEY_END   = 8'd4;
  localparam logic [7:0] KEY_HOME  = 8'd5;
  localparam logic [7:0] KEY_F1    = 8'd6;
  localparam logic [7:0] KEY_INS   = 8'd10;
  localparam logic [7:0] KEY_DEL   = 8'd11;
  localparam logic [7:0] KEY_PGUP  = 8'd12;
  localparam logic [7:0] KEY_PGDN  = 8'd13;
  localparam logic [7:0] KEY_F7    = 8'd14;
  localparam logic [7:0] KEY_BKSP  = 8'd15;

  // sequence bookkeeping
  localparam logic [2:0] SEQ_EMPTY = 3'd0;
  localparam logic [2:0] SEQ_FULL  = 3'd6;
  localparam logic [2:0] SEQ_OVER  = 3'd7;

  // bytes 1..4 of an open sequence (byte 0 is always ESC)
  typedef logic [3:0][7:0] seq_buf_t;

  // decoder verdict for one byte
  typedef struct packed {
    logic       emit;
    logic       is_named;
    logic [7:0] key_value;
    logic [2:0] len_nxt;
    logic       store;
    logic [1:0] store_idx;
  } dec_t;

endpackage

[rtl/tekd_match.sv]
// tekd_match: per-byte escape sequence decode against the held sequence bytes
`timescale 1ns / 1ps

module tekd_match (
  input  logic               [7:0] rx_byte,
  input  logic               [2:0] seq_len,
  input  tekd_pkg::seq_buf_t       seq_buf,
  output tekd_pkg::dec_t           dec
);

  logic [2:0] pos;
  logic [2:0] len_new;
  logic [7:0] b1;
  logic [7:0] b2;
  logic [7:0] b3;
  logic [7:0] b4;

  assign b1 = seq_buf[0];
  assign b2 = seq_buf[1];
  assign b3 = seq_buf[2];
  assign b4 = seq_buf[3];

  // write position of this byte, with the over-length count clamped to SEQ_FULL
  assign pos     = (seq_len == tekd_pkg::SEQ_OVER) ? tekd_pkg::SEQ_FULL : seq_len;
  assign len_new = pos + 3'd1;

  // classify byte and match patterns at each length
  always_comb begin
    dec           = '0;
    dec.key_value = rx_byte;
    dec.len_nxt   = tekd_pkg::SEQ_EMPTY;
    dec.store_idx = 2'(pos - 3'd1);
    if (rx_byte == tekd_pkg::BYTE_NUL || rx_byte == tekd_pkg::BYTE_ETX) begin
      dec.emit = 1'b1;
    end else if (seq_len == tekd_pkg::SEQ_EMPTY && rx_byte != tekd_pkg::BYTE_ESC) begin
      dec.emit = 1'b1;
      if (rx_byte == tekd_pkg::BYTE_DEL) begin
        dec.is_named  = 1'b1;
        dec.key_value = tekd_pkg::KEY_BKSP;
      end
    end else begin
      dec.len_nxt = len_new;
      dec.store   = (pos >= 3'd1) && (pos <= 3'd4);
      case (len_new)
        3'd3: begin
          if (b1 == tekd_pkg::BYTE_CSI) begin
            case (rx_byte)
              8'd65: dec.key_value = tekd_pkg::KEY_UP;
              8'd66: dec.key_value = tekd_pkg::KEY_DOWN;
              8'd67: dec.key_value = tekd_pkg::KEY_RIGHT;
              8'd68: dec.key_value = tekd_pkg::KEY_LEFT;
              8'd70: dec.key_value = tekd_pkg::KEY_END;
              8'd72: dec.key_value = tekd_pkg::KEY_HOME;
              default: dec.key_value = rx_byte;
            endcase
            dec.emit = rx_byte inside {8'd65, 8'd66, 8'd67, 8'd68, 8'd70, 8'd72};
          end else if (b1 == tekd_pkg::BYTE_SS3 && rx_byte inside {[8'd80:8'd83]}) begin
            dec.emit      = 1'b1;
            dec.key_value = tekd_pkg::KEY_F1 + {6'd0, rx_byte[1:0]};
          end
        end
        3'd4: begin
          if (b1 == tekd_pkg::BYTE_CSI && rx_byte == tekd_pkg::BYTE_TILDE) begin
            case (b2)
              8'd50: dec.key_value = tekd_pkg::KEY_INS;
              8'd51: dec.key_value = tekd_pkg::KEY_DEL;
              8'd53: dec.key_value = tekd_pkg::KEY_PGUP;
              8'd54: dec.key_value = tekd_pkg::KEY_PGDN;
              default: dec.key_value = rx_byte;
            endcase
            dec.emit = b2 inside {8'd50, 8'd51, 8'd53, 8'd54};
          end
        end
        3'd5: begin
          if (b1 == tekd_pkg::BYTE_CSI && rx_byte == tekd_pkg::BYTE_TILDE) begin
            if (b2 == 8'd49 && b3 == 8'd56) begin
              dec.emit      = 1'b1;
              dec.key_value = tekd_pkg::KEY_F7;
            end else if (b2 == 8'd49 && b3 inside {8'd53, 8'd55, 8'd57}) begin
              dec.len_nxt = tekd_pkg::SEQ_EMPTY;
            end else if (b2 == 8'd50 && b3 inside {8'd48, 8'd49, 8'd51, 8'd52}) begin
              dec.len_nxt = tekd_pkg::SEQ_EMPTY;
            end
          end
        end
        3'd6: begin
          // shift/ctrl F1-F4 are swallowed
          if (b1 == tekd_pkg::BYTE_CSI && b2 == 8'd49 && b3 == 8'd59 &&
              b4 inside {8'd50, 8'd53} && rx_byte inside {[8'd80:8'd83]}) begin
            dec.len_nxt = tekd_pkg::SEQ_EMPTY;
          end
        end
        3'd7: dec.len_nxt = tekd_pkg::SEQ_EMPTY;
        default: dec.len_nxt = len_new;
      endcase
      if (dec.emit) begin
        dec.is_named = 1'b1;
        dec.len_nxt  = tekd_pkg::SEQ_EMPTY;
      end
    end
  end

endmodule

[rtl/terminal_escape_key_decoder.sv]
// terminal_escape_key_decoder: top level of the VT100/ANSI key sequence decoder
//
// Usage: one terminal byte per transaction enters on in_valid/in_ready/in_rx_byte.
// Each byte yields zero or one result on out_valid/out_ready with out_is_named
// and out_key_value: a plain character (is_named 0) or a key number (is_named 1).
// Bytes of an ESC sequence are held until a pattern matches, a silent pattern
// closes the sequence, a NUL or ETX byte arrives, or seven bytes have been seen.
// Path: an accepted byte is captured in the input register and decoded from it;
// its result, if any, is then held in the result register.
// Throughput: one byte per cycle while the receiver does not stall, as the input
// register is decoded combinationally against the four held sequence bytes and the length counter.
// Reset (rst_n low, synchronous) empties both pipeline registers and closes any
// open sequence; the held sequence bytes are not cleared.
// Receiver stall: the result register holds its transaction; the input register
// takes one more byte, then in_ready drops until the result is taken. A byte that
// yields no result still waits behind a stalled result to keep the order.
`timescale 1ns / 1ps

module terminal_escape_key_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_is_named,
  output logic [7:0] out_key_value
);

  logic               s1_valid_r;
  logic [7:0]         s1_byte_r;
  logic [2:0]         seq_len_r;
  tekd_pkg::seq_buf_t seq_buf_r;
  logic               out_valid_r;
  logic               out_is_named_r;
  logic [7:0]         out_key_value_r;
  logic               out_free;
  logic               s1_go;
  tekd_pkg::dec_t     dec;

  // handshake
  assign out_free = !out_valid_r || out_ready;
  assign s1_go    = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || s1_go;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  // pattern decode
  tekd_match u_match (
    .rx_byte (s1_byte_r),
    .seq_len (seq_len_r),
    .seq_buf (seq_buf_r),
    .dec     (dec)
  );

  // sequence length
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_len_r <= tekd_pkg::SEQ_EMPTY;
    end else if (s1_go) begin
      seq_len_r <= dec.len_nxt;
    end
  end

  // held sequence bytes
  always_ff @(posedge clk) begin
    if (s1_go && dec.store) begin
      seq_buf_r[dec.store_idx] <= s1_byte_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_go && dec.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && dec.emit) begin
      out_is_named_r  <= dec.is_named;
      out_key_value_r <= dec.key_value;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_is_named  = out_is_named_r;
  assign out_key_value = out_key_value_r;

  // the over-length count never persists
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    seq_len_r != tekd_pkg::SEQ_OVER)
    else $error("sequence length register holds the over-length count");

  // named keys stay within the key table
  a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_is_named_r |-> out_key_value_r <= tekd_pkg::KEY_BKSP)
    else $error("named key number out of range");

  // ESC and DEL never leave as plain characters
  a_plain_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_is_named_r |->
      out_key_value_r != tekd_pkg::BYTE_ESC && out_key_value_r != tekd_pkg::BYTE_DEL)
    else $error("ESC or DEL emitted as plain character");

  // a byte blocked behind a stalled result keeps its place
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_go |=> s1_valid_r && $stable(s1_byte_r) && $stable(seq_len_r))
    else $error("blocked byte or sequence state changed");

endmodule
